// ===== src/cat_pkg.sv =====
// Shared types, codes and constants for the connection admission table.
// No dependencies.
`default_nettype none
package cat_pkg;
  localparam int TableDepth = 64;
  localparam int IdxW = $clog2(TableDepth);
  localparam int CntW = $clog2(TableDepth + 1);
  localparam int EntW = 32 + 48 + 48;

  localparam logic [2:0] ACT_CONNECT = 3'd0;
  localparam logic [2:0] ACT_DISCONNECT = 3'd1;
  localparam logic [2:0] ACT_FORWARD = 3'd2;
  localparam logic [2:0] ACT_START = 3'd3;
  localparam logic [2:0] ACT_STOP = 3'd4;
  localparam logic [2:0] ACT_QUERY = 3'd5;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_STOPPED = 3'd1;
  localparam logic [2:0] ST_FULL = 3'd2;
  localparam logic [2:0] ST_ACL = 3'd3;
  localparam logic [2:0] ST_RATIO = 3'd4;
  localparam logic [2:0] ST_NOTFOUND = 3'd5;
  localparam logic [2:0] ST_OVERLOAD = 3'd6;
  localparam logic [2:0] ST_ZEROLEN = 3'd7;

  localparam logic CFG_RATIO = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef struct packed {
    logic [31:0] id;
    logic [47:0] bin;
    logic [47:0] bout;
  } entry_t;
endpackage
`default_nettype wire

// ===== src/cat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module cat_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/connection_admission_table.sv =====
// Top level: connection table sequencer that scans the table entry by entry.
// Depends on cat_pkg and cat_ram.
//
//  Channel | Ports                          | Direction
//  input   | in_valid/in_stall + fields     | into block
//  result  | out_valid/out_stall + fields   | out of block
//  config  | cfg_we/cfg_index/cfg_data      | into block
//
// Without a scan an item passes from the accept state through the decision state (S_CAP)
// and a finishing state (S_DONE) to the result state (S_OUT). Disconnect, query and a running
// forward with nonzero length scan the table, reading (S_RD) and comparing (S_CMP) one entry
// at a time: a miss visits every entry and a hit stops at its slot; a disconnect hit then
// moves the last entry into the freed slot (S_LAST, S_MOVE). One item is handled at a time.
// Reset is synchronous; the table needs no clearing pass.
// The result beat holds in the output register while out_stall is high.
`default_nettype none
module connection_admission_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_conn_id,
  input  wire logic        in_direction,
  input  wire logic [15:0] in_length,
  input  wire logic        in_acl_permits,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_status,
  output logic [31:0]      out_id_out,
  output logic [15:0]      out_forwarded_len,
  output logic [47:0]      out_entry_bytes_in,
  output logic [47:0]      out_entry_bytes_out,
  output logic [31:0]      out_active_stat,
  output logic [31:0]      out_rejected_total,
  output logic [31:0]      out_opened_total,
  output logic [47:0]      out_bytes_in_total,
  output logic [47:0]      out_bytes_out_total,
  output logic [31:0]      out_packets_in_total,
  output logic [31:0]      out_packets_out_total,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);
  import cat_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD = 3'd1;
  localparam logic [2:0] S_CMP = 3'd2;
  localparam logic [2:0] S_LAST = 3'd3;
  localparam logic [2:0] S_MOVE = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;
  localparam logic [2:0] S_OUT = 3'd6;
  localparam logic [2:0] S_CAP = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [6:0] ratio_r;
  logic [31:0] limit_r;
  logic running_r;
  logic [CntW-1:0] count_r;
  logic [31:0] next_id_r;
  logic [IdxW-1:0] scan_r, hit_r;
  logic [2:0] act_r;
  logic [31:0] id_r;
  logic dir_r, acl_r;
  logic [15:0] len_r;

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t wdata, rdata;

  cat_ram #(.Width(EntW), .Depth(TableDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign in_stall = (state_r != S_IDLE);
  logic acc;
  assign acc = in_valid && !in_stall;

  // Ratio cap max(1, depth * ratio / 100) without a divider. The count reaches
  // floor(depth * ratio / 100) exactly when depth * ratio < (count + 1) * 100.
  logic [13:0] cap_num, cap_den;
  logic cap_hit;
  assign cap_num = 14'(ratio_r) * 14'(TableDepth);
  assign cap_den = (14'(count_r) + 14'd1) * 14'd100;
  assign cap_hit = (count_r != '0) && (cap_num < cap_den);

  logic conn_ok, fwd_ok;
  assign conn_ok = running_r && count_r < CntW'(TableDepth) && acl_r && !cap_hit;
  assign fwd_ok = (act_r == ACT_FORWARD) && ({16'd0, len_r} <= limit_r);

  // Read address: scan index normally, the last entry while moving it.
  always_comb begin
    raddr = scan_r;
    if (state_r == S_LAST) raddr = IdxW'(count_r - CntW'(1));
  end

  logic [47:0] sum_in, sum_out;
  assign sum_in = rdata.bin + 48'(len_r);
  assign sum_out = rdata.bout + 48'(len_r);

  always_comb begin
    we = 1'b0;
    waddr = hit_r;
    wdata = rdata;
    if (state_r == S_CMP && rdata.id == id_r && fwd_ok) begin
      we = 1'b1;
      waddr = scan_r;
      if (!dir_r) wdata.bin = sum_in; else wdata.bout = sum_out;
    end else if (state_r == S_MOVE) begin
      we = 1'b1;
    end else if (state_r == S_CAP && act_r == ACT_CONNECT && conn_ok) begin
      we = 1'b1;
      waddr = IdxW'(count_r);
      wdata.id = next_id_r;
      wdata.bin = '0;
      wdata.bout = '0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (acc) state_nxt = S_CAP;
      S_CAP: begin
        if (act_r == ACT_DISCONNECT || act_r == ACT_QUERY ||
            (act_r == ACT_FORWARD && len_r != 16'd0 && running_r)) begin
          state_nxt = (count_r == '0) ? S_DONE : S_RD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RD: state_nxt = S_CMP;
      S_CMP: begin
        if (rdata.id == id_r)
          state_nxt = (act_r == ACT_DISCONNECT) ? S_LAST : S_DONE;
        else if (CntW'(scan_r) + CntW'(1) >= count_r) state_nxt = S_DONE;
        else state_nxt = S_RD;
      end
      S_LAST: state_nxt = S_MOVE;
      S_MOVE: state_nxt = S_DONE;
      S_DONE: state_nxt = S_OUT;
      S_OUT: if (!out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ratio_r <= 7'd100;
      limit_r <= 32'hFFFF_FFFF;
      running_r <= 1'b0;
      count_r <= '0;
      next_id_r <= 32'd1;
      out_active_stat <= '0;
      out_rejected_total <= '0;
      out_opened_total <= '0;
      out_bytes_in_total <= '0;
      out_bytes_out_total <= '0;
      out_packets_in_total <= '0;
      out_packets_out_total <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_RATIO: ratio_r <= (cfg_data[6:0] > 7'd100) ? 7'd100 : cfg_data[6:0];
          CFG_LIMIT: limit_r <= cfg_data;
        endcase
      end
      if (state_r == S_CAP) begin
        unique case (act_r)
          ACT_START: running_r <= 1'b1;
          ACT_STOP: if (running_r) begin
            running_r <= 1'b0;
            count_r <= '0;
          end
          ACT_CONNECT: if (running_r && count_r < CntW'(TableDepth)) begin
            if (!acl_r || cap_hit) out_rejected_total <= out_rejected_total + 32'd1;
            else begin
              next_id_r <= next_id_r + 32'd1;
              count_r <= count_r + CntW'(1);
              out_opened_total <= out_opened_total + 32'd1;
              out_active_stat <= out_active_stat + 32'd1;
            end
          end
          default: ;
        endcase
      end
      if (we && state_r == S_CMP) begin
        if (!dir_r) begin
          out_bytes_in_total <= out_bytes_in_total + 48'(len_r);
          out_packets_in_total <= out_packets_in_total + 32'd1;
        end else begin
          out_bytes_out_total <= out_bytes_out_total + 48'(len_r);
          out_packets_out_total <= out_packets_out_total + 32'd1;
        end
      end
      if (state_r == S_MOVE) begin
        count_r <= count_r - CntW'(1);
        out_active_stat <= out_active_stat - 32'd1;
      end
    end
  end

  assign out_valid = (state_r == S_OUT);

  // Payload, scan and result registers.
  always_ff @(posedge clk) begin
    if (acc) begin
      act_r <= in_action;
      id_r <= in_conn_id;
      dir_r <= in_direction;
      len_r <= in_length;
      acl_r <= in_acl_permits;
      scan_r <= '0;
    end
    if (state_r == S_IDLE && acc) begin
      out_status <= ST_OK;
      out_id_out <= in_conn_id;
      out_forwarded_len <= '0;
      out_entry_bytes_in <= '0;
      out_entry_bytes_out <= '0;
    end
    if (state_r == S_CAP) begin
      unique case (act_r)
        ACT_CONNECT: begin
          if (!running_r) out_status <= ST_STOPPED;
          else if (count_r >= CntW'(TableDepth)) out_status <= ST_FULL;
          else if (!acl_r) out_status <= ST_ACL;
          else if (cap_hit) out_status <= ST_RATIO;
          out_id_out <= conn_ok ? next_id_r : '0;
        end
        ACT_FORWARD: begin
          if (len_r == 16'd0) out_status <= ST_ZEROLEN;
          else if (!running_r) out_status <= ST_STOPPED;
          else out_status <= ST_NOTFOUND;
        end
        ACT_DISCONNECT, ACT_QUERY: out_status <= ST_NOTFOUND;
        default: ;
      endcase
    end
    if (state_r == S_CMP) begin
      if (rdata.id == id_r) begin
        hit_r <= scan_r;
        out_status <= (act_r == ACT_FORWARD && !fwd_ok) ? ST_OVERLOAD : ST_OK;
        out_entry_bytes_in <= (fwd_ok && !dir_r) ? sum_in : rdata.bin;
        out_entry_bytes_out <= (fwd_ok && dir_r) ? sum_out : rdata.bout;
        if (fwd_ok) out_forwarded_len <= len_r;
      end else begin
        scan_r <= scan_r + IdxW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ===== src/cat_checker.sv =====
// Port-level checker for the connection admission table, bound to the top.
// Depends on cat_pkg and the top-level port list.
`default_nettype none
module cat_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  out_status,
  input wire logic [15:0] out_forwarded_len
);
  import cat_pkg::*;

  property p_busy;
    @(posedge clk) disable iff (!rst_n) (in_valid && !in_stall) |=> in_stall;
  endproperty
  a_busy: assert property (p_busy) else $error("accepted item did not block input");

  property p_hold;
    @(posedge clk) disable iff (!rst_n) (out_valid && out_stall) |=> out_valid;
  endproperty
  a_hold: assert property (p_hold) else $error("stalled result dropped");

  property p_fwd;
    @(posedge clk) disable iff (!rst_n)
      (out_valid && out_forwarded_len != 16'd0) |-> (out_status == ST_OK);
  endproperty
  a_fwd: assert property (p_fwd) else $error("forwarded length on a failed item");

  property p_excl;
    @(posedge clk) disable iff (!rst_n) out_valid |-> in_stall;
  endproperty
  a_excl: assert property (p_excl) else $error("input open while result pending");
endmodule

bind connection_admission_table cat_checker u_cat_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
  .out_forwarded_len(out_forwarded_len)
);
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the connection admission table.
// Depends on cat_pkg and the connection_admission_table RTL; predicts every
// result beat in a local model of the table and compares it field by field.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import cat_pkg::*;

  // Action codes outside the defined set; the block answers them with no effect.
  localparam logic [2:0] ACT_RSVD_A = 3'd6;
  localparam logic [2:0] ACT_RSVD_B = 3'd7;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] id_out;
    logic [15:0] fwd_len;
    logic [47:0] ebin;
    logic [47:0] ebout;
    logic [31:0] active;
    logic [31:0] rejected;
    logic [31:0] opened;
    logic [47:0] bin_tot;
    logic [47:0] bout_tot;
    logic [31:0] pin_tot;
    logic [31:0] pout_tot;
  } conn_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [31:0] in_conn_id = '0;
  logic        in_direction = 1'b0;
  logic [15:0] in_length = '0;
  logic        in_acl_permits = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  conn_result_t dut_res;

  connection_admission_table i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_conn_id(in_conn_id), .in_direction(in_direction), .in_length(in_length),
    .in_acl_permits(in_acl_permits),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(dut_res.status), .out_id_out(dut_res.id_out),
    .out_forwarded_len(dut_res.fwd_len), .out_entry_bytes_in(dut_res.ebin),
    .out_entry_bytes_out(dut_res.ebout), .out_active_stat(dut_res.active),
    .out_rejected_total(dut_res.rejected), .out_opened_total(dut_res.opened),
    .out_bytes_in_total(dut_res.bin_tot), .out_bytes_out_total(dut_res.bout_tot),
    .out_packets_in_total(dut_res.pin_tot), .out_packets_out_total(dut_res.pout_tot),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow state of the table.
  logic [6:0]  mdl_ratio;
  logic [31:0] mdl_limit;
  bit          mdl_running;
  int          mdl_count;
  logic [31:0] mdl_next_id;
  logic [31:0] mdl_ids [TableDepth];
  logic [47:0] mdl_in_bytes [TableDepth];
  logic [47:0] mdl_out_bytes [TableDepth];
  conn_result_t mdl_tot;

  conn_result_t expected_q[$];
  int  errors = 0;
  bit  idle_ok = 1'b1;
  bit  long_hold = 1'b0;
  longint cycles = 0;

  function automatic int find_entry(logic [31:0] id);
    for (int i = 0; i < mdl_count; i++) if (mdl_ids[i] == id) return i;
    return -1;
  endfunction

  function automatic conn_result_t predict_action(logic [2:0] act, logic [31:0] id,
                                                  logic dir, logic [15:0] len,
                                                  logic acl);
    conn_result_t r;
    int cap;
    int idx;
    r = '0;
    r.id_out = id;
    case (act)
      ACT_CONNECT: begin
        cap = (TableDepth * mdl_ratio) / 100;
        if (cap == 0) cap = 1;
        r.id_out = '0;
        if (!mdl_running) r.status = ST_STOPPED;
        else if (mdl_count >= TableDepth) r.status = ST_FULL;
        else if (!acl) begin
          r.status = ST_ACL;
          mdl_tot.rejected++;
        end else if (mdl_count >= cap) begin
          r.status = ST_RATIO;
          mdl_tot.rejected++;
        end else begin
          r.id_out = mdl_next_id;
          mdl_next_id++;
          mdl_ids[mdl_count] = r.id_out;
          mdl_in_bytes[mdl_count] = '0;
          mdl_out_bytes[mdl_count] = '0;
          mdl_count++;
          mdl_tot.opened++;
          mdl_tot.active++;
        end
      end
      ACT_DISCONNECT: begin
        idx = find_entry(id);
        if (idx < 0) r.status = ST_NOTFOUND;
        else begin
          r.ebin = mdl_in_bytes[idx];
          r.ebout = mdl_out_bytes[idx];
          mdl_tot.active--;
          mdl_ids[idx] = mdl_ids[mdl_count-1];
          mdl_in_bytes[idx] = mdl_in_bytes[mdl_count-1];
          mdl_out_bytes[idx] = mdl_out_bytes[mdl_count-1];
          mdl_count--;
        end
      end
      ACT_FORWARD: begin
        idx = find_entry(id);
        if (len == 0) r.status = ST_ZEROLEN;
        else if (!mdl_running) r.status = ST_STOPPED;
        else if (idx < 0) r.status = ST_NOTFOUND;
        else begin
          if ({16'd0, len} > mdl_limit) r.status = ST_OVERLOAD;
          else begin
            r.fwd_len = len;
            if (!dir) begin
              mdl_in_bytes[idx] += 48'(len);
              mdl_tot.bin_tot += 48'(len);
              mdl_tot.pin_tot++;
            end else begin
              mdl_out_bytes[idx] += 48'(len);
              mdl_tot.bout_tot += 48'(len);
              mdl_tot.pout_tot++;
            end
          end
          r.ebin = mdl_in_bytes[idx];
          r.ebout = mdl_out_bytes[idx];
        end
      end
      ACT_START: mdl_running = 1'b1;
      ACT_STOP: begin
        if (mdl_running) begin
          mdl_running = 1'b0;
          mdl_count = 0;
        end
      end
      ACT_QUERY: begin
        idx = find_entry(id);
        if (idx < 0) r.status = ST_NOTFOUND;
        else begin
          r.ebin = mdl_in_bytes[idx];
          r.ebout = mdl_out_bytes[idx];
        end
      end
      default: ;
    endcase
    r.active = mdl_tot.active;
    r.rejected = mdl_tot.rejected;
    r.opened = mdl_tot.opened;
    r.bin_tot = mdl_tot.bin_tot;
    r.bout_tot = mdl_tot.bout_tot;
    r.pin_tot = mdl_tot.pin_tot;
    r.pout_tot = mdl_tot.pout_tot;
    return r;
  endfunction

  // Sends one beat; the expectation is queued at the accepting edge.
  // The previous beat's valid drops at the last falling edge, so this one
  // starts no earlier than the next.
  task automatic send_item(logic [2:0] act, logic [31:0] id, logic dir,
                           logic [15:0] len, logic acl);
    int gap;
    gap = 1;
    if (idle_ok && $urandom_range(0, 5) == 0) gap += $urandom_range(1, 6);
    repeat (gap) @(negedge clk);
    in_valid <= 1'b1;
    in_action <= act;
    in_conn_id <= id;
    in_direction <= dir;
    in_length <= len;
    in_acl_permits <= acl;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(predict_action(act, id, dir, len, acl));
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (expected_q.size() != 0) @(negedge clk);
    // Start and stop need no scan; lookups may scan the whole table.
    repeat (4 + 2 * TableDepth + 10) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_RATIO) mdl_ratio = (value[6:0] > 100) ? 7'd100 : value[6:0];
    else mdl_limit = value;
  endtask

  function automatic logic [31:0] pick_id();
    if (mdl_count > 0 && $urandom_range(0, 9) < 8) return mdl_ids[$urandom_range(0, mdl_count-1)];
    return $urandom_range(0, 3) == 0 ? $urandom() : mdl_next_id + $urandom_range(0, 3);
  endfunction

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 5))
      0: return 16'hFFFF;
      1: return 16'd0;
      2: return 16'($urandom_range(1, 16));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_items(int n, int connect_weight);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < connect_weight)
        send_item(ACT_CONNECT, $urandom(), 1'($urandom()), 16'($urandom()),
                  $urandom_range(0, 7) != 0);
      else if (pick < connect_weight + 30)
        send_item(ACT_FORWARD, pick_id(), 1'($urandom()), pick_len(), 1'($urandom()));
      else if (pick < connect_weight + 45)
        send_item(ACT_DISCONNECT, pick_id(), 1'($urandom()), 16'($urandom()),
                  1'($urandom()));
      else if (pick < connect_weight + 60)
        send_item(ACT_QUERY, pick_id(), 1'($urandom()), 16'($urandom()), 1'($urandom()));
      else if (pick < 97)
        send_item(ACT_START, $urandom(), 1'($urandom()), 16'($urandom()), 1'($urandom()));
      else if (pick < 99)
        send_item(ACT_STOP, $urandom(), 1'($urandom()), 16'($urandom()), 1'($urandom()));
      else
        send_item(($urandom_range(0, 1) == 0) ? ACT_RSVD_A : ACT_RSVD_B, $urandom(),
                  1'($urandom()), 16'($urandom()), 1'($urandom()));
    end
  endtask

  task automatic test_directed();
    send_item(ACT_CONNECT, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1);
    send_item(ACT_FORWARD, 32'd1, 1'b0, 16'd5, 1'b0);
    send_item(ACT_STOP, '0, 1'b0, '0, 1'b0);
    send_item(ACT_START, '0, 1'b0, '0, 1'b0);
    send_item(ACT_START, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 1'b1);
    send_item(ACT_CONNECT, '0, 1'b0, '0, 1'b0);
    send_item(ACT_CONNECT, '0, 1'b0, '0, 1'b1);
    send_item(ACT_CONNECT, '0, 1'b1, '0, 1'b1);
    send_item(ACT_FORWARD, 32'd1, 1'b0, 16'hFFFF, 1'b0);
    send_item(ACT_FORWARD, 32'd2, 1'b1, 16'd1, 1'b1);
    send_item(ACT_FORWARD, 32'd1, 1'b0, 16'd0, 1'b0);
    send_item(ACT_FORWARD, 32'h1234_5678, 1'b0, 16'd3, 1'b0);
    send_item(ACT_QUERY, 32'd1, 1'b0, '0, 1'b0);
    send_item(ACT_QUERY, 32'hFFFF_FFFF, 1'b0, '0, 1'b0);
    send_item(ACT_RSVD_A, 32'hA5A5_A5A5, 1'b1, 16'hFFFF, 1'b1);
    send_item(ACT_RSVD_B, 32'd0, 1'b0, 16'd0, 1'b0);
    send_item(ACT_DISCONNECT, 32'd1, 1'b0, '0, 1'b0);
    send_item(ACT_DISCONNECT, 32'd1, 1'b0, '0, 1'b0);
    send_item(ACT_QUERY, 32'd2, 1'b0, '0, 1'b0);
    send_item(ACT_STOP, '0, 1'b0, '0, 1'b0);
    send_item(ACT_DISCONNECT, 32'd2, 1'b0, '0, 1'b0);
    send_item(ACT_FORWARD, 32'd2, 1'b0, 16'd1, 1'b0);
    drain_results();
  endtask

  task automatic test_length_limit();
    write_reg(CFG_LIMIT, 32'd0);
    send_item(ACT_START, '0, 1'b0, '0, 1'b0);
    send_item(ACT_CONNECT, '0, 1'b0, '0, 1'b1);
    send_item(ACT_FORWARD, mdl_next_id - 1, 1'b0, 16'd1, 1'b0);
    drain_results();
    write_reg(CFG_LIMIT, 32'd1000);
    random_items(150, 25);
    drain_results();
    write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
  endtask

  // Fills the table to its cap at several ratio settings, and to full where the ratio is 100 or more.
  task automatic test_ratio_cap();
    logic [31:0] ratios [5] = '{32'd0, 32'd1, 32'd50, 32'd127, 32'd100};
    foreach (ratios[k]) begin
      send_item(ACT_STOP, '0, 1'b0, '0, 1'b0);
      drain_results();
      write_reg(CFG_RATIO, ratios[k]);
      send_item(ACT_START, '0, 1'b0, '0, 1'b0);
      for (int i = 0; i < TableDepth + 3; i++)
        send_item(ACT_CONNECT, $urandom(), 1'($urandom()), 16'($urandom()), 1'b1);
      random_items(40, 20);
      drain_results();
    end
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    random_items(20, 40);
    long_hold = 1'b0;
    drain_results();
  endtask

  // Mixed random traffic; the last stretch runs with no idle cycles on either side.
  task automatic test_random();
    random_items(250, 25);
    idle_ok = 1'b0;
    random_items(100, 25);
  endtask

  // Receiver side: random stall bursts, or one long hold.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        n = 300;
        while (n > 0) begin
          @(negedge clk);
          n--;
        end
        out_stall <= 1'b0;
        wait (!long_hold);
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 6);
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Result checker.
  initial begin
    conn_result_t exp_r;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %p", $realtime, dut_res);
          errors++;
        end else begin
          exp_r = expected_q.pop_front();
          if (dut_res !== exp_r) begin
            $display("%0t: mismatch expected %p", $realtime, exp_r);
            $display("%0t:          actual   %p", $realtime, dut_res);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 2_000_000) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    mdl_ratio = 7'd100;
    mdl_limit = 32'hFFFF_FFFF;
    mdl_running = 1'b0;
    mdl_count = 0;
    mdl_next_id = 32'd1;
    mdl_tot = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_length_limit();
    test_ratio_cap();
    test_backpressure();
    test_random();
    drain_results();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
